// ===== rtl/core/tilt_pkg.sv =====
`default_nettype none

package tilt_pkg;

    // Angle formats and CORDIC length.
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ATAN_FRAC         = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam int ATAN_IDX_W        = $clog2(ATAN_ENTRIES);
    localparam int ROUND_SHIFT       = ATAN_FRAC - ANGLE_FRAC_BITS;

    // Square root of (a^2 + b^2) * 2^24.
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 31;
    localparam int SQRT_IN_W  = SUM_W + 24;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;

    // CORDIC vector and angle accumulator width.
    localparam int VEC_W = 32;

    // Shared multiplier.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ALPHA_W = 17;
    localparam int STEP_W  = 24;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] BLEND_RESET = 17'd64225;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd167772;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 2'd1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } tilt_in_t;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
    } tilt_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_DONE,
        ST_ROOT_GO,
        ST_ROOT_RUN,
        ST_ATAN_GO,
        ST_ATAN_RUN,
        ST_GYRO,
        ST_PRED,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_C,
        ST_DONE
    } tilt_state_t;

    // atan(2^-i) in degrees with 24 fraction bits.
    function automatic logic signed [VEC_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [VEC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd754974720;
            5'd1:    v = 32'sd445687602;
            5'd2:    v = 32'sd235489088;
            5'd3:    v = 32'sd119537938;
            5'd4:    v = 32'sd60000934;
            5'd5:    v = 32'sd30029717;
            5'd6:    v = 32'sd15018523;
            5'd7:    v = 32'sd7509720;
            5'd8:    v = 32'sd3754917;
            5'd9:    v = 32'sd1877466;
            5'd10:   v = 32'sd938734;
            5'd11:   v = 32'sd469367;
            5'd12:   v = 32'sd234684;
            5'd13:   v = 32'sd117342;
            5'd14:   v = 32'sd58671;
            5'd15:   v = 32'sd29335;
            5'd16:   v = 32'sd14668;
            5'd17:   v = 32'sd7334;
            5'd18:   v = 32'sd3667;
            5'd19:   v = 32'sd1833;
            5'd20:   v = 32'sd917;
            5'd21:   v = 32'sd458;
            5'd22:   v = 32'sd229;
            5'd23:   v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tilt_sqrt.sv =====
`default_nettype none

module tilt_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tilt_pkg::SQRT_IN_W-1:0]  radicand,
    output logic                            busy,
    output logic [tilt_pkg::SQRT_OUT_W-1:0] root
);
    import tilt_pkg::*;

    localparam logic [SQRT_IN_W-1:0] TOP_PROBE = SQRT_IN_W'(1) << (SQRT_IN_W - 2);

    logic                 busy_reg;
    logic [SQRT_IN_W-1:0] rem_reg;
    logic [SQRT_IN_W-1:0] res_reg;
    logic [SQRT_IN_W-1:0] probe_reg;
    logic [SQRT_IN_W-1:0] trial;

    assign trial = res_reg + probe_reg;
    assign busy  = busy_reg;
    assign root  = res_reg[SQRT_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && probe_reg[0])
        begin
            busy_reg <= 1'b0;
        end
    end

    // One result bit per cycle, probing powers of four from the top down.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= radicand;
            res_reg   <= '0;
            probe_reg <= TOP_PROBE;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + probe_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            probe_reg <= probe_reg >> 2;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tilt_cordic.sv =====
`default_nettype none

module tilt_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tilt_pkg::VEC_W-1:0] x_start,
    input  logic signed [tilt_pkg::VEC_W-1:0] y_start,
    output logic                              busy,
    output logic signed [tilt_pkg::VEC_W-1:0] angle
);
    import tilt_pkg::*;

    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

    logic                    busy_reg;
    logic [ATAN_IDX_W-1:0]   step_reg;
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [VEC_W-1:0] z_reg;
    logic signed [VEC_W-1:0] x_sh;
    logic signed [VEC_W-1:0] y_sh;
    logic signed [VEC_W-1:0] atan_step;

    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign atan_step = atan_q24(step_reg);
    assign busy      = busy_reg;
    assign angle     = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Vectoring mode: rotate toward y = 0 and accumulate the angle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_start;
            y_reg <= y_start;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[VEC_W-1])
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_step;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_step;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/imu_complementary_tilt_filter.sv =====
`default_nettype none
// An accepted item passes through the square states (ST_SQ_X to ST_SQ_DONE), then per angle
// through a 28-step square root and a 16-step CORDIC, then per angle through the multiply-and-blend
// states (ST_GYRO, ST_PRED, ST_MIX_A to ST_MIX_C), and ST_DONE loads the result into the output register.
// A new item is taken only in ST_IDLE, after the last one is loaded; both angles share the square root and CORDIC.
// Reset clears the stored pitch and roll to zero and loads the default blend weight
// and step time; the output register comes up empty.

module imu_complementary_tilt_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tilt_pkg::tilt_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tilt_pkg::tilt_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [tilt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tilt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tilt_pkg::*;

    localparam logic signed [VEC_W:0]     ANG_HALF = (VEC_W + 1)'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [MUL_P_W-1:0] MUL_HALF = MUL_P_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [MUL_P_W-1:0] MIX_HALF = MUL_P_W'(32768);

    tilt_state_t state_reg, state_next;

    logic [ALPHA_W-1:0]        blend_weight_reg;
    logic [STEP_W-1:0]         step_time_reg;
    tilt_in_t                  in_reg;
    logic [SQ_W-1:0]           sx_reg;
    logic [SQ_W-1:0]           sy_reg;
    logic [SQ_W-1:0]           sz_reg;
    logic                      side_reg;
    logic                      zero_reg;
    logic signed [VEC_W-1:0]   accel_p_reg;
    logic signed [VEC_W-1:0]   accel_r_reg;
    logic signed [31:0]        pitch_reg;
    logic signed [31:0]        roll_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] mix_reg;
    logic signed [MUL_A_W-1:0] pred_reg;
    tilt_out_t                 out_reg;
    logic                      out_valid_reg;

    logic                      sqrt_start;
    logic                      sqrt_busy;
    logic [SQRT_OUT_W-1:0]     sqrt_root;
    logic                      cordic_start;
    logic                      cordic_busy;
    logic signed [VEC_W-1:0]   cordic_angle;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [ALPHA_W-1:0]        alpha;
    logic signed [15:0]        num;
    logic [SUM_W-1:0]          sum_sq;
    logic signed [15:0]        gyro;
    logic signed [31:0]        old_angle;
    logic signed [VEC_W-1:0]   accel;
    logic signed [VEC_W:0]     angle_rnd;
    logic signed [MUL_P_W-1:0] gterm;
    logic signed [MUL_P_W-1:0] mix_sum;
    logic signed [MUL_P_W-17:0] blended;
    logic signed [31:0]        blended_sat;
    logic                      out_free;

    assign alpha     = (blend_weight_reg > ALPHA_ONE) ? ALPHA_ONE : blend_weight_reg;
    assign num       = side_reg ? in_reg.accel_y : in_reg.accel_x;
    assign sum_sq    = side_reg ? (SUM_W'(sx_reg) + SUM_W'(sz_reg))
                                : (SUM_W'(sy_reg) + SUM_W'(sz_reg));
    assign gyro      = side_reg ? in_reg.gyro_y : in_reg.gyro_x;
    assign old_angle = side_reg ? roll_reg : pitch_reg;
    assign accel     = side_reg ? accel_r_reg : accel_p_reg;
    assign angle_rnd = ((VEC_W + 1)'(cordic_angle) + ANG_HALF) >>> ROUND_SHIFT;
    assign gterm     = (prod_reg + MUL_HALF) >>> ROUND_SHIFT;
    assign mix_sum   = mix_reg + prod_reg + MIX_HALF;
    assign blended   = mix_sum[MUL_P_W-1:16];
    assign mul_p     = mul_a * mul_b;
    assign out_free  = !out_valid_reg || !out_stall;

    // Saturate the blend to the signed 32-bit range.
    always_comb
    begin
        if (blended[MUL_P_W-17:31] == '0 || blended[MUL_P_W-17:31] == '1)
        begin
            blended_sat = blended[31:0];
        end
        else if (blended[MUL_P_W-17])
        begin
            blended_sat = {1'b1, 31'd0};
        end
        else
        begin
            blended_sat = {1'b0, {31{1'b1}}};
        end
    end

    tilt_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sum_sq, 24'd0}),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    tilt_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .x_start (VEC_W'(sqrt_root)),
        .y_start (VEC_W'(num) <<< 12),
        .busy    (cordic_busy),
        .angle   (cordic_angle)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_SQ_X;
            ST_SQ_X:     state_next = ST_SQ_Y;
            ST_SQ_Y:     state_next = ST_SQ_Z;
            ST_SQ_Z:     state_next = ST_SQ_DONE;
            ST_SQ_DONE:  state_next = ST_ROOT_GO;
            ST_ROOT_GO:  state_next = ST_ROOT_RUN;
            ST_ROOT_RUN: if (!sqrt_busy) state_next = ST_ATAN_GO;
            ST_ATAN_GO:  state_next = ST_ATAN_RUN;
            ST_ATAN_RUN:
            begin
                if (!cordic_busy)
                begin
                    state_next = side_reg ? ST_GYRO : ST_ROOT_GO;
                end
            end
            ST_GYRO:     state_next = ST_PRED;
            ST_PRED:     state_next = ST_MIX_A;
            ST_MIX_A:    state_next = ST_MIX_B;
            ST_MIX_B:    state_next = ST_MIX_C;
            ST_MIX_C:    state_next = side_reg ? ST_DONE : ST_GYRO;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_IDLE:    in_stall = 1'b0;
            ST_SQ_X:
            begin
                mul_a = MUL_A_W'(in_reg.accel_x);
                mul_b = MUL_B_W'(in_reg.accel_x);
            end
            ST_SQ_Y:
            begin
                mul_a = MUL_A_W'(in_reg.accel_y);
                mul_b = MUL_B_W'(in_reg.accel_y);
            end
            ST_SQ_Z:
            begin
                mul_a = MUL_A_W'(in_reg.accel_z);
                mul_b = MUL_B_W'(in_reg.accel_z);
            end
            ST_ROOT_GO: sqrt_start = 1'b1;
            ST_ATAN_GO: cordic_start = 1'b1;
            ST_GYRO:
            begin
                mul_a = MUL_A_W'({1'b0, step_time_reg});
                mul_b = MUL_B_W'(gyro);
            end
            ST_MIX_A:
            begin
                mul_a = pred_reg;
                mul_b = MUL_B_W'({1'b0, alpha});
            end
            ST_MIX_B:
            begin
                mul_a = MUL_A_W'(accel);
                mul_b = MUL_B_W'({1'b0, ALPHA_ONE - alpha});
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            blend_weight_reg <= BLEND_RESET;
            step_time_reg    <= STEP_RESET;
            pitch_reg        <= '0;
            roll_reg         <= '0;
            side_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLEND_WEIGHT: blend_weight_reg <= cfg_data[ALPHA_W-1:0];
                    REG_STEP_TIME:    step_time_reg    <= cfg_data[STEP_W-1:0];
                    default:          ;
                endcase
            end

            if (state_reg == ST_ATAN_RUN && !cordic_busy)
            begin
                side_reg <= !side_reg;
            end
            if (state_reg == ST_MIX_C)
            begin
                side_reg <= !side_reg;
                if (side_reg)
                begin
                    roll_reg <= blended_sat;
                end
                else
                begin
                    pitch_reg <= blended_sat;
                end
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_reg <= in_data;
                end
            end
            ST_SQ_Y:    sx_reg <= prod_reg[SQ_W-1:0];
            ST_SQ_Z:    sy_reg <= prod_reg[SQ_W-1:0];
            ST_SQ_DONE: sz_reg <= prod_reg[SQ_W-1:0];
            ST_ROOT_GO: zero_reg <= (num == '0) && (sum_sq == '0);
            ST_ATAN_RUN:
            begin
                if (!cordic_busy)
                begin
                    // Both atan2 arguments zero gives a zero angle.
                    if (side_reg)
                    begin
                        accel_r_reg <= zero_reg ? '0 : angle_rnd[VEC_W-1:0];
                    end
                    else
                    begin
                        accel_p_reg <= zero_reg ? '0 : angle_rnd[VEC_W-1:0];
                    end
                end
            end
            ST_PRED:    pred_reg <= MUL_A_W'(old_angle) + gterm[MUL_A_W-1:0];
            ST_MIX_B:   mix_reg <= prod_reg;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_reg.pitch_out <= pitch_reg;
                    out_reg.roll_out  <= roll_reg;
                end
            end
            default:    ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
